// File: hdl/gcsp_pkg.sv
// Package of the greedy cutting-stock packer: field widths, codes and the result type.
package gcsp_pkg;

  // Store depth used when no other value is given.
  localparam int unsigned MaxPiecesDef = 32;

  // Field widths.
  localparam int unsigned CountW  = 6;
  localparam int unsigned LenW    = 16;
  localparam int unsigned KerfW   = 8;
  localparam int unsigned BarW    = 6;
  localparam int unsigned TWasteW = 21;
  localparam int unsigned StatusW = 2;

  // Configuration register indexes and reset values.
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegBarLength = 1'd0;
  localparam logic [CfgIdxW-1:0] RegKerf      = 1'd1;
  localparam logic [LenW-1:0]    BarLengthRst = 16'd5800;
  localparam logic [KerfW-1:0]   KerfRst      = 8'd2;

  // Result status codes.
  localparam logic [StatusW-1:0] StatusOk       = 2'd0;
  localparam logic [StatusW-1:0] StatusNoFit    = 2'd1;
  localparam logic [StatusW-1:0] StatusOverflow = 2'd2;

  // One result item.
  typedef struct packed {
    logic [BarW-1:0]    bar_number;
    logic [LenW-1:0]    cut_len;
    logic               piece_valid;
    logic               bar_done;
    logic [LenW-1:0]    bar_waste;
    logic [BarW-1:0]    total_bars;
    logic [TWasteW-1:0] total_waste;
    logic [StatusW-1:0] status;
    logic               last;
  } out_item_t;

endpackage

// File: hdl/greedy_cutting_stock_packer.sv
// Greedy largest-fit cutting-stock packer with a one-port piece store memory.
// Loading: each group beat is accepted in S_LOAD, then its copies are written to the store in S_WRITE.
// Packing: each cut, each bar close and the closing search cost a scan of the store
// (N pieces stored, one memory read a cycle); the no-fit report then visits each entry,
// after which the final beat is issued; a held output beat stalls.
// Reset clears the count, used bits, overflow flag and sequencer; the store is not cleared.
// Configuration resets to a bar length of 5800 mm and a kerf of 2 mm.
module greedy_cutting_stock_packer
  import gcsp_pkg::*;
#(
  parameter int unsigned MAX_PIECES = MaxPiecesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Fields from bit 0: piece_count[5:0], piece_length[21:6], zero fill.
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tlast,   // last_group
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: bar_number[5:0], cut_len[21:6], bar_done[22],
  // bar_waste[38:23], total_bars[44:39], total_waste[65:45], zero fill.
  output logic [71:0] m_axis_tdata,
  // Fields from bit 0: piece_valid[0], status[2:1].
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [LenW-1:0]     cfg_wdata_i
);

  localparam int unsigned IdxW = $clog2(MAX_PIECES);
  localparam int unsigned CntW = $clog2(MAX_PIECES + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_PIECES);

  typedef enum logic [2:0] {
    S_LOAD, S_WRITE, S_SCAN, S_CUT, S_REP_RD, S_REP_EMIT, S_FINAL
  } state_e;

  state_e              state_q;
  logic [LenW-1:0]     bar_length_q;
  logic [KerfW-1:0]    kerf_q;
  logic [CntW-1:0]     stored_q;
  logic                overflow_q;
  logic [MAX_PIECES-1:0] used_q;
  logic [CountW-1:0]   cnt_q;
  logic [LenW-1:0]     len_q;
  logic                lastg_q;
  logic [CntW-1:0]     rd_ptr_q;
  logic                rv_q;
  logic [IdxW-1:0]     ridx_q;
  logic                best_found_q;
  logic [IdxW-1:0]     best_idx_q;
  logic [LenW-1:0]     best_len_q;
  logic [LenW-1:0]     remain_q;
  logic                bar_cut_q;
  logic [BarW-1:0]     bars_q;
  logic [TWasteW-1:0]  waste_q;
  out_item_t           pend_q;
  logic                pend_valid_q;
  out_item_t           out_q;
  logic                out_valid_q;

  // Piece store and its registered read port.
  logic [LenW-1:0]     mem_q [MAX_PIECES];
  logic [LenW-1:0]     rdata_q;
  logic                wr_en;
  logic                rd_en;
  logic [IdxW-1:0]     rd_idx;

  logic                out_free;
  logic                out_load;
  logic [LenW:0]       cand_need;
  logic                cand_fits;
  logic [LenW:0]       cut_need;
  out_item_t           final_item;
  out_item_t           cut_item;
  out_item_t           nofit_item;
  out_item_t           closed_item;

  assign rd_idx   = rd_ptr_q[IdxW-1:0];
  assign wr_en    = (state_q == S_WRITE) && (cnt_q != '0) && (stored_q < MaxCnt);
  assign rd_en    = ((state_q == S_SCAN) && (rd_ptr_q < stored_q)) ||
                    ((state_q == S_REP_RD) && (rd_ptr_q < stored_q) && !used_q[rd_idx]);
  assign out_free = !out_valid_q || m_axis_tready;

  // The output register takes a new beat when the pending beat moves on or at the end.
  assign out_load = ((state_q == S_CUT) && best_found_q && pend_valid_q && out_free) ||
                    ((state_q == S_REP_EMIT) && pend_valid_q && out_free) ||
                    ((state_q == S_FINAL) && out_free);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[stored_q[IdxW-1:0]] <= len_q;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_idx];
    end
  end

  // Candidate test on the entry returned by the store: unused, fits, strictly longer.
  assign cand_need = {1'b0, rdata_q} + (LenW+1)'(kerf_q);
  assign cand_fits = !used_q[ridx_q] && (cand_need < {1'b0, remain_q}) &&
                     (!best_found_q || (rdata_q > best_len_q));
  assign cut_need  = {1'b0, best_len_q} + (LenW+1)'(kerf_q);

  // Beats built for a cut, a no-fit report and a bar close.
  always_comb begin
    cut_item             = '0;
    cut_item.bar_number  = bars_q;
    cut_item.cut_len     = best_len_q;
    cut_item.piece_valid = 1'b1;
    cut_item.status      = StatusOk;
    nofit_item             = '0;
    nofit_item.cut_len     = rdata_q;
    nofit_item.piece_valid = 1'b1;
    nofit_item.status      = StatusNoFit;
    closed_item           = pend_q;
    closed_item.bar_done  = 1'b1;
    closed_item.bar_waste = remain_q;
  end

  // Final beat carries totals, the last mark and the overflow report.
  always_comb begin
    final_item = pend_valid_q ? pend_q : '0;
    final_item.total_bars  = bars_q;
    final_item.total_waste = waste_q;
    final_item.last        = 1'b1;
    if (overflow_q) begin
      final_item.status = StatusOverflow;
    end
  end

  assign s_axis_tready = (state_q == S_LOAD);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tuser  = {out_q.status, out_q.piece_valid};
  assign m_axis_tdata  = {6'b0, out_q.total_waste, out_q.total_bars, out_q.bar_waste,
                          out_q.bar_done, out_q.cut_len, out_q.bar_number};

  // Sequencer: store loading, scans, cuts, report and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      bar_length_q <= BarLengthRst;
      kerf_q       <= KerfRst;
      stored_q     <= '0;
      overflow_q   <= 1'b0;
      used_q       <= '0;
      cnt_q        <= '0;
      len_q        <= '0;
      lastg_q      <= 1'b0;
      rd_ptr_q     <= '0;
      rv_q         <= 1'b0;
      ridx_q       <= '0;
      best_found_q <= 1'b0;
      best_idx_q   <= '0;
      best_len_q   <= '0;
      remain_q     <= '0;
      bar_cut_q    <= 1'b0;
      bars_q       <= '0;
      waste_q      <= '0;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegBarLength: bar_length_q <= cfg_wdata_i;
          RegKerf:      kerf_q       <= cfg_wdata_i[KerfW-1:0];
          default:      ;
        endcase
      end

      out_valid_q <= out_load || (out_valid_q && !m_axis_tready);

      case (state_q)
        // Take one group beat.
        S_LOAD: begin
          if (s_axis_tvalid) begin
            cnt_q   <= s_axis_tdata[CountW-1:0];
            len_q   <= s_axis_tdata[CountW+LenW-1:CountW];
            lastg_q <= s_axis_tlast;
            state_q <= S_WRITE;
          end
        end

        // Write the group's copies, one entry a cycle; surplus sets the overflow flag.
        S_WRITE: begin
          if (cnt_q != '0) begin
            cnt_q <= cnt_q - 1'b1;
            if (stored_q < MaxCnt) begin
              stored_q <= stored_q + 1'b1;
            end else begin
              overflow_q <= 1'b1;
            end
          end else if (lastg_q) begin
            remain_q     <= bar_length_q;
            bar_cut_q    <= 1'b0;
            bars_q       <= '0;
            waste_q      <= '0;
            rd_ptr_q     <= '0;
            rv_q         <= 1'b0;
            best_found_q <= 1'b0;
            state_q      <= S_SCAN;
          end else begin
            state_q <= S_LOAD;
          end
        end

        // Stream the store through the candidate test.
        S_SCAN: begin
          if (rv_q && cand_fits) begin
            best_found_q <= 1'b1;
            best_idx_q   <= ridx_q;
            best_len_q   <= rdata_q;
          end
          if (rd_ptr_q < stored_q) begin
            rd_ptr_q <= rd_ptr_q + 1'b1;
            ridx_q   <= rd_idx;
            rv_q     <= 1'b1;
          end else begin
            rv_q <= 1'b0;
            if (!rv_q) begin
              state_q <= S_CUT;
            end
          end
        end

        // Cut the best piece, close the bar, or move on to the report.
        S_CUT: begin
          if (best_found_q) begin
            if (!pend_valid_q || out_free) begin
              if (pend_valid_q) begin
                out_q <= pend_q;
              end
              pend_q             <= cut_item;
              pend_valid_q       <= 1'b1;
              used_q[best_idx_q] <= 1'b1;
              remain_q           <= remain_q - cut_need[LenW-1:0];
              bar_cut_q          <= 1'b1;
              rd_ptr_q           <= '0;
              best_found_q       <= 1'b0;
              state_q            <= S_SCAN;
            end
          end else if (bar_cut_q) begin
            pend_q    <= closed_item;
            waste_q   <= waste_q + TWasteW'(remain_q);
            bars_q    <= bars_q + 1'b1;
            remain_q  <= bar_length_q;
            bar_cut_q <= 1'b0;
            rd_ptr_q  <= '0;
            state_q   <= S_SCAN;
          end else begin
            rd_ptr_q <= '0;
            state_q  <= S_REP_RD;
          end
        end

        // Look for the next piece that was never cut.
        S_REP_RD: begin
          if (rd_ptr_q >= stored_q) begin
            state_q <= S_FINAL;
          end else begin
            rd_ptr_q <= rd_ptr_q + 1'b1;
            if (!used_q[rd_idx]) begin
              state_q <= S_REP_EMIT;
            end
          end
        end

        // Queue the no-fit piece behind the pending beat.
        S_REP_EMIT: begin
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_q <= pend_q;
            end
            pend_q       <= nofit_item;
            pend_valid_q <= 1'b1;
            state_q      <= S_REP_RD;
          end
        end

        // Issue the final beat and empty the store for the next batch.
        S_FINAL: begin
          if (out_free) begin
            out_q        <= final_item;
            pend_valid_q <= 1'b0;
            stored_q     <= '0;
            overflow_q   <= 1'b0;
            used_q       <= '0;
            state_q      <= S_LOAD;
          end
        end

        default: state_q <= S_LOAD;
      endcase
    end
  end

  // The store count never passes its depth.
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= MaxCnt)
    else $error("piece count beyond store depth");

  // A new group is only taken once no result beat is left pending.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !pend_valid_q)
    else $error("group accepted with a result still pending");

  // A cut only ever takes a piece that is still unused.
  a_cut_unused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CUT && best_found_q) |-> !used_q[best_idx_q])
    else $error("cut selected a piece already used");

  // After the final beat the store is empty.
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL && out_free) |=> (stored_q == '0 && used_q == '0 && out_valid_q))
    else $error("store not emptied after the final beat");

endmodule
